// ===== hdl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and tables for the differential-drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES     = 24;

    // serial multiplier operand widths (both signed)
    localparam int MUL_WA = 34;
    localparam int MUL_WB = 34;
    localparam int MUL_WP = MUL_WA + MUL_WB;

    // CORDIC datapath widths
    localparam int CS_W = 34;
    localparam int Z_W  = 35;

    localparam int WRAP_W     = 30;
    localparam int WRAP_STEPS = 13;

    localparam logic signed [WRAP_W-1:0] TWO_PI_Q13 = 30'sd51472;
    localparam logic signed [WRAP_W-1:0] PI_Q13     = 30'sd25736;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30     = 35'sd1686629713;
    localparam logic signed [Z_W-1:0]  PI_Q30          = 35'sd3373259426;

    localparam logic [1:0] REG_TIME_STEP     = 2'd0;
    localparam logic [1:0] REG_INVERSE_TRACK = 2'd1;
    localparam logic [1:0] REG_FILTER_WEIGHT = 2'd2;

    localparam logic [15:0] RST_TIME_STEP     = 16'd655;
    localparam logic [15:0] RST_INVERSE_TRACK = 16'd1249;
    localparam logic [15:0] RST_FILTER_WEIGHT = 16'd6554;

    typedef struct packed {
        logic signed [15:0] left_wheel_speed;
        logic signed [15:0] right_wheel_speed;
    } t_odo_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [15:0] fwd_speed;
        logic signed [15:0] turn_rate;
    } t_odo_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILT,
        S_FILTW,
        S_RATE,
        S_RATEW,
        S_HEAD,
        S_HEADW,
        S_WRAP,
        S_CORD,
        S_CORDW,
        S_POS,
        S_POSW,
        S_OUT
    } t_state;

    // arctan(2^-i) in Q2.30
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd843314857;
            5'd1:    v = 32'd497837829;
            5'd2:    v = 32'd263043837;
            5'd3:    v = 32'd133525159;
            5'd4:    v = 32'd67021687;
            5'd5:    v = 32'd33543516;
            5'd6:    v = 32'd16775851;
            5'd7:    v = 32'd8388437;
            5'd8:    v = 32'd4194283;
            5'd9:    v = 32'd2097149;
            5'd10:   v = 32'd1048576;
            5'd11:   v = 32'd524288;
            5'd12:   v = 32'd262144;
            5'd13:   v = 32'd131072;
            5'd14:   v = 32'd65536;
            5'd15:   v = 32'd32768;
            5'd16:   v = 32'd16384;
            5'd17:   v = 32'd8192;
            5'd18:   v = 32'd4096;
            5'd19:   v = 32'd2048;
            5'd20:   v = 32'd1024;
            5'd21:   v = 32'd512;
            5'd22:   v = 32'd256;
            5'd23:   v = 32'd128;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/ddo_mul.sv =====
// ----------------------------------------------------------------------------
// ddo_mul
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_mul #(
    parameter int WA = ddo_pkg::MUL_WA,
    parameter int WB = ddo_pkg::MUL_WB
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic                    o_done,
    output logic signed [WA+WB-1:0] o_p
);
    import ddo_pkg::*;

    localparam int CW = $clog2(WB);

    logic                    r_busy;
    logic                    r_done;
    logic [CW-1:0]           r_cnt;
    logic signed [WA-1:0]    r_a;
    logic [WA+WB-1:0]        r_p;
    logic [WA+WB-1:0]        n_p;
    logic                    last;
    logic signed [WA:0]      hi;
    logic signed [WA:0]      addend;
    logic signed [WA:0]      sum;

    assign last = (r_cnt == CW'(WB - 1));

    always_comb begin
        hi = $signed({r_p[WA+WB-1], r_p[WA+WB-1 -: WA]});
        if (r_p[0]) begin
            // multiplier sign bit carries negative weight
            addend = last ? -$signed({r_a[WA-1], r_a}) : $signed({r_a[WA-1], r_a});
        end else begin
            addend = '0;
        end
        sum = hi + addend;
        n_p = {sum, r_p[WB-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{WA{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= n_p;
        end
    end

    assign o_done = r_done;
    assign o_p    = $signed(r_p);

endmodule

// ===== hdl/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ddo_cordic #(
    parameter int STEPS = ddo_pkg::DEF_CORDIC_STEPS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [15:0]             i_head,
    output logic                           o_done,
    output logic signed [ddo_pkg::CS_W-1:0] o_cos,
    output logic signed [ddo_pkg::CS_W-1:0] o_sin
);
    import ddo_pkg::*;

    localparam int STEPS_EFF = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;

    logic                   r_busy;
    logic                   r_done;
    logic [4:0]             r_i;
    logic                   r_flip;
    logic signed [CS_W-1:0] r_x;
    logic signed [CS_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;
    logic signed [CS_W-1:0] r_c;
    logic signed [CS_W-1:0] r_s;

    logic signed [Z_W-1:0]  z0;
    logic signed [Z_W-1:0]  z_in;
    logic                   flip_in;
    logic signed [CS_W-1:0] xs;
    logic signed [CS_W-1:0] ys;
    logic signed [CS_W-1:0] n_x;
    logic signed [CS_W-1:0] n_y;
    logic signed [Z_W-1:0]  n_z;
    logic signed [Z_W-1:0]  at;
    logic                   last;

    always_comb begin
        z0 = $signed({{(Z_W-16){i_head[15]}}, i_head}) <<< 17;
        // fold into the right half plane
        if (z0 > HALF_PI_Q30) begin
            z_in    = z0 - PI_Q30;
            flip_in = 1'b1;
        end else if (z0 < -HALF_PI_Q30) begin
            z_in    = z0 + PI_Q30;
            flip_in = 1'b1;
        end else begin
            z_in    = z0;
            flip_in = 1'b0;
        end
    end

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = $signed({{(Z_W-32){1'b0}}, atan_q30(r_i)});
        if (!r_z[Z_W-1]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - at;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + at;
        end
        last = (r_i == 5'(STEPS_EFF - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= z_in;
            r_flip <= flip_in;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            if (last) begin
                r_c <= r_flip ? -n_x : n_x;
                r_s <= r_flip ? -n_y : n_y;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_c;
    assign o_sin  = r_s;

endmodule

// ===== hdl/diff_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Dead-reckoning odometry for a two-wheeled base: filtered speeds, turn rate,
// wrapped heading and saturating position.
// ----------------------------------------------------------------------------
// One tick is processed at a time. Its work is set by the two bit-serial
// multipliers, each taking one multiplier bit per cycle over four product
// rounds, plus a heading wrap of WRAP_STEPS conditional subtracts and the
// micro-rotations of the CORDIC. A finished result sits in the output
// register while the next tick is taken; the registers are to be written
// over the APB port only while the block is idle, which the block itself
// does not enforce.
module diff_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::DEF_CORDIC_STEPS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ddo_pkg::t_odo_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ddo_pkg::t_odo_out o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ddo_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [15:0]               r_ts;
    logic [15:0]               r_inv;
    logic [15:0]               r_w;

    logic signed [15:0]        r_inl;
    logic signed [15:0]        r_inr;
    logic signed [15:0]        r_lf;
    logic signed [15:0]        r_rf;
    logic signed [15:0]        r_lin;
    logic signed [15:0]        r_ang;
    logic signed [15:0]        r_head;
    logic signed [31:0]        r_x;
    logic signed [31:0]        r_y;
    logic signed [32:0]        r_rate;
    logic signed [31:0]        r_dist;
    logic signed [WRAP_W-1:0]  r_wrap;
    logic [3:0]                r_wcnt;

    logic                      r_ovalid;
    t_odo_out                  r_out;

    logic                      mul_start;
    logic                      cor_start;
    logic signed [MUL_WA-1:0]  a0;
    logic signed [MUL_WA-1:0]  a1;
    logic signed [MUL_WB-1:0]  b0;
    logic signed [MUL_WB-1:0]  b1;
    logic                      done0;
    logic                      done1;
    logic signed [MUL_WP-1:0]  p0;
    logic signed [MUL_WP-1:0]  p1;
    logic                      cor_done;
    logic signed [CS_W-1:0]    cos_v;
    logic signed [CS_W-1:0]    sin_v;

    logic signed [16:0]        lin_sum;
    logic signed [15:0]        lin_c;
    logic                      cfg_wr;
    logic                      out_take;

    // ---------------------------------------------------------------------
    // rounding and saturation helpers
    function automatic logic signed [15:0] f_filt(input logic signed [MUL_WP-1:0] p,
                                                 input logic signed [15:0] old);
        logic signed [34:0] acc;
        logic signed [18:0] sh;
        logic signed [15:0] res;
        acc = $signed({{3{old[15]}}, old, 16'd0}) + p[34:0] + 35'sd32768;
        sh  = acc[34:16];
        if (sh > 19'sd32767) begin
            res = 16'sh7FFF;
        end else if (sh < -19'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = sh[15:0];
        end
        return res;
    endfunction

    function automatic logic signed [15:0] f_ang(input logic signed [MUL_WP-1:0] p);
        logic signed [34:0] acc;
        logic signed [23:0] sh;
        logic signed [15:0] res;
        acc = p[34:0] + 35'sd1024;
        sh  = acc[34:11];
        if (sh > 24'sd32767) begin
            res = 16'sh7FFF;
        end else if (sh < -24'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = sh[15:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] f_pos(input logic signed [MUL_WP-1:0] p,
                                                input logic signed [31:0] acc);
        logic signed [MUL_WP-1:0] rnd;
        logic signed [32:0]       sum;
        logic signed [31:0]       res;
        rnd = p + (68'sd1 <<< 41);
        sum = $signed({acc[31], acc}) + $signed({{7{rnd[67]}}, rnd[67:42]});
        if (sum > 33'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (sum < -33'sh0_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = sum[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [WRAP_W-1:0] f_head_sum(
        input logic signed [MUL_WP-1:0] p, input logic signed [15:0] head);
        logic signed [MUL_WP-1:0] rnd;
        logic signed [WRAP_W-1:0] t;
        rnd = p + (68'sd1 <<< 22);
        t   = $signed({{(WRAP_W-16){head[15]}}, head}) + rnd[52:23] + PI_Q13;
        // lift negatives by a multiple of 2*pi before the reduction
        if (t < 0) begin
            t = t + (TWO_PI_Q13 <<< 12);
        end
        return t;
    endfunction

    // ---------------------------------------------------------------------
    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_TIME_STEP:     prdata = {16'd0, r_ts};
            REG_INVERSE_TRACK: prdata = {16'd0, r_inv};
            REG_FILTER_WEIGHT: prdata = {16'd0, r_w};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts  <= RST_TIME_STEP;
            r_inv <= RST_INVERSE_TRACK;
            r_w   <= RST_FILTER_WEIGHT;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TIME_STEP:     r_ts  <= pwdata[15:0];
                REG_INVERSE_TRACK: r_inv <= pwdata[15:0];
                REG_FILTER_WEIGHT: r_w   <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // arithmetic units
    assign lin_sum = $signed({r_lf[15], r_lf}) + $signed({r_rf[15], r_rf}) + 17'sd1;
    assign lin_c   = lin_sum[16:1];

    always_comb begin
        a0 = '0;
        a1 = '0;
        b0 = '0;
        b1 = '0;
        case (r_state)
            S_FILT: begin
                a0 = MUL_WA'($signed({r_inl[15], r_inl}) - $signed({r_lf[15], r_lf}));
                a1 = MUL_WA'($signed({r_inr[15], r_inr}) - $signed({r_rf[15], r_rf}));
                b0 = $signed({{(MUL_WB-16){1'b0}}, r_w});
                b1 = $signed({{(MUL_WB-16){1'b0}}, r_w});
            end
            S_RATE: begin
                a0 = MUL_WA'($signed({r_rf[15], r_rf}) - $signed({r_lf[15], r_lf}));
                a1 = MUL_WA'(lin_c);
                b0 = $signed({{(MUL_WB-16){1'b0}}, r_inv});
                b1 = $signed({{(MUL_WB-16){1'b0}}, r_ts});
            end
            S_HEAD: begin
                a0 = MUL_WA'(r_rate);
                b0 = $signed({{(MUL_WB-16){1'b0}}, r_ts});
            end
            S_POS: begin
                a0 = MUL_WA'(r_dist);
                a1 = MUL_WA'(r_dist);
                b0 = cos_v;
                b1 = sin_v;
            end
            default: ;
        endcase
    end

    ddo_mul #(.WA(MUL_WA), .WB(MUL_WB)) u_mul0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (a0),
        .i_b     (b0),
        .o_done  (done0),
        .o_p     (p0)
    );

    ddo_mul #(.WA(MUL_WA), .WB(MUL_WB)) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (a1),
        .i_b     (b1),
        .o_done  (done1),
        .o_p     (p1)
    );

    ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_head  (r_head),
        .o_done  (cor_done),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    // ---------------------------------------------------------------------
    // sequencer
    assign out_take = r_ovalid && i_out_ready;

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        cor_start = 1'b0;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_FILT;
            S_FILT: begin
                mul_start = 1'b1;
                n_state   = S_FILTW;
            end
            S_FILTW: if (done0 && done1) n_state = S_RATE;
            S_RATE: begin
                mul_start = 1'b1;
                n_state   = S_RATEW;
            end
            S_RATEW: if (done0 && done1) n_state = S_HEAD;
            S_HEAD: begin
                mul_start = 1'b1;
                n_state   = S_HEADW;
            end
            S_HEADW: if (done0) n_state = S_WRAP;
            S_WRAP:  if (r_wcnt == 4'd0) n_state = S_CORD;
            S_CORD: begin
                cor_start = 1'b1;
                n_state   = S_CORDW;
            end
            S_CORDW: if (cor_done) n_state = S_POS;
            S_POS: begin
                mul_start = 1'b1;
                n_state   = S_POSW;
            end
            S_POSW:  if (done0 && done1) n_state = S_OUT;
            S_OUT:   if (!r_ovalid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lf   <= '0;
            r_rf   <= '0;
            r_head <= '0;
            r_x    <= '0;
            r_y    <= '0;
        end else begin
            case (r_state)
                S_FILTW: begin
                    if (done0 && done1) begin
                        r_lf <= f_filt(p0, r_lf);
                        r_rf <= f_filt(p1, r_rf);
                    end
                end
                S_WRAP: begin
                    if (r_wcnt == 4'd0) begin
                        r_head <= 16'(((r_wrap >= TWO_PI_Q13) ? r_wrap - TWO_PI_Q13 : r_wrap)
                                      - PI_Q13);
                    end
                end
                S_POSW: begin
                    if (done0 && done1) begin
                        r_x <= f_pos(p0, r_x);
                        r_y <= f_pos(p1, r_y);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_inl <= i_in_data.left_wheel_speed;
                    r_inr <= i_in_data.right_wheel_speed;
                end
            end
            S_RATE: r_lin <= lin_c;
            S_RATEW: begin
                if (done0 && done1) begin
                    r_rate <= p0[32:0];
                    r_dist <= p1[31:0];
                    r_ang  <= f_ang(p0);
                end
            end
            S_HEADW: begin
                if (done0) begin
                    r_wrap <= f_head_sum(p0, r_head);
                    r_wcnt <= 4'(WRAP_STEPS - 1);
                end
            end
            S_WRAP: begin
                // one conditional subtract of 2*pi*2^k per cycle
                if (r_wrap >= (TWO_PI_Q13 <<< r_wcnt)) begin
                    r_wrap <= r_wrap - (TWO_PI_Q13 <<< r_wcnt);
                end
                r_wcnt <= r_wcnt - 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && (!r_ovalid || i_out_ready)) begin
            r_ovalid <= 1'b1;
        end else if (out_take) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || i_out_ready)) begin
            r_out.pos_x     <= r_x;
            r_out.pos_y     <= r_y;
            r_out.heading   <= r_head;
            r_out.fwd_speed <= r_lin;
            r_out.turn_rate <= r_ang;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/ddo_chk.sv =====
// ----------------------------------------------------------------------------
// ddo_chk
// Port-level checks for the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module ddo_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input ddo_pkg::t_odo_out o_out_data,
    input logic              pready
);
    import ddo_pkg::*;

    // one tick at a time: no back-to-back transfer on the input
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice in a row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (($signed(o_out_data.heading) >= -16'sd25736) &&
                         ($signed(o_out_data.heading) <= 16'sd25735)))
        else $error("heading outside -pi..pi");

    // no result appears in the cycle after a tick is taken while none is pending
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> !o_out_valid)
        else $error("result appeared too early");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind diff_drive_odometry ddo_chk u_ddo_chk (.*);

// ===== tb/diff_drive_odometry_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_tb
// Drives wheel-speed ticks through the odometry block under random flow
// control and register settings. Each returned pose is checked field by field
// against a fixed-point odometry predictor kept alongside the block.
// ----------------------------------------------------------------------------
module diff_drive_odometry_tb;
    import ddo_pkg::*;

    localparam int   NUM_STEPS  = 16;
    localparam int   LIMIT      = 3000000;
    localparam int   SETTLE     = 250;
    localparam longint TWO_PI   = 51472;
    localparam longint PI_Q     = 25736;
    localparam longint GAIN     = 652032874;
    localparam longint HALF_PI  = 1686629713;
    localparam longint PI_WIDE  = 64'sd3373259426;
    localparam longint POS_MAX  = 64'sd2147483647;
    localparam longint POS_MIN  = -64'sd2147483648;

    // ------------------------------------------------------------------------
    class odo_scoreboard;
        longint step_t, inv_track, weight;
        longint left_f, right_f, head, xpos, ypos;
        t_odo_out poses[$];
        int errors;
        int checked;
        longint arctan[24];

        function new();
            arctan = '{843314857, 497837829, 263043837, 133525159, 67021687,
                       33543516, 16775851, 8388437, 4194283, 2097149,
                       1048576, 524288, 262144, 131072, 65536, 32768,
                       16384, 8192, 4096, 2048, 1024, 512, 256, 128};
            step_t = RST_TIME_STEP;
            inv_track = RST_INVERSE_TRACK;
            weight = RST_FILTER_WEIGHT;
            left_f = 0; right_f = 0; head = 0; xpos = 0; ypos = 0;
            errors = 0;
            checked = 0;
        endfunction

        function longint rnd(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void sincos(longint h, output longint c, output longint s);
            longint z, x, y, nx;
            bit flip;
            z = h * 131072;
            x = GAIN;
            y = 0;
            flip = 0;
            if (z > HALF_PI) begin
                z -= PI_WIDE; flip = 1;
            end else if (z < -HALF_PI) begin
                z += PI_WIDE; flip = 1;
            end
            for (int i = 0; i < NUM_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i); y = y + (x >>> i); z -= arctan[i];
                end else begin
                    nx = x + (y >>> i); y = y - (x >>> i); z += arctan[i];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note_tick(t_odo_in t);
            longint keep, lin, rate, ang, h, c, s, travel;
            t_odo_out p;
            keep = 65536 - weight;
            left_f = sat(rnd(keep * left_f + weight * longint'(t.left_wheel_speed), 16),
                         -32768, 32767);
            right_f = sat(rnd(keep * right_f + weight * longint'(t.right_wheel_speed), 16),
                          -32768, 32767);
            lin = (left_f + right_f + 1) >>> 1;
            rate = (right_f - left_f) * inv_track;
            ang = sat(rnd(rate, 11), -32768, 32767);
            h = head + rnd(rate * step_t, 23);
            h = (h + PI_Q) % TWO_PI;
            if (h < 0) h += TWO_PI;
            head = h - PI_Q;
            sincos(head, c, s);
            travel = lin * step_t;
            xpos = sat(xpos + rnd(travel * c, 42), POS_MIN, POS_MAX);
            ypos = sat(ypos + rnd(travel * s, 42), POS_MIN, POS_MAX);
            p.pos_x = xpos[31:0];
            p.pos_y = ypos[31:0];
            p.heading = head[15:0];
            p.fwd_speed = lin[15:0];
            p.turn_rate = ang[15:0];
            poses.push_back(p);
        endfunction

        function void check_pose(t_odo_out got);
            t_odo_out exp_p;
            checked++;
            if (poses.size() == 0) begin
                $error("pose transfer with nothing outstanding");
                errors++;
                return;
            end
            exp_p = poses.pop_front();
            if (got.pos_x !== exp_p.pos_x) begin
                $error("pos_x: expected %0d, got %0d", exp_p.pos_x, got.pos_x); errors++;
            end
            if (got.pos_y !== exp_p.pos_y) begin
                $error("pos_y: expected %0d, got %0d", exp_p.pos_y, got.pos_y); errors++;
            end
            if (got.heading !== exp_p.heading) begin
                $error("heading: expected %0d, got %0d", exp_p.heading, got.heading);
                errors++;
            end
            if (got.fwd_speed !== exp_p.fwd_speed) begin
                $error("fwd_speed: expected %0d, got %0d",
                       exp_p.fwd_speed, got.fwd_speed);
                errors++;
            end
            if (got.turn_rate !== exp_p.turn_rate) begin
                $error("turn_rate: expected %0d, got %0d",
                       exp_p.turn_rate, got.turn_rate);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_odo_in   i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_odo_out  o_out_data;
    logic      psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic      pready;

    diff_drive_odometry dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    odo_scoreboard sb = new();
    int  hold_request = 0;
    int  ticks_sent = 0;
    bit  running = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial begin
        int run;
        int hold;
        run = 0;
        hold = 0;
        i_out_ready <= 0;
        forever begin
            @(posedge i_clk);
            if (running && o_out_valid && i_out_ready) sb.check_pose(o_out_data);
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 0;
            end else if (run > 0) begin
                run--;
            end else if ($urandom_range(0, 3) != 0) begin
                run = $urandom_range(0, 40);
                i_out_ready <= 1;
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                 : $urandom_range(0, 4);
                i_out_ready <= 0;
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_TIME_STEP:     sb.step_t = val;
            REG_INVERSE_TRACK: sb.inv_track = val;
            REG_FILTER_WEIGHT: sb.weight = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.poses.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] ts, input logic [15:0] it,
                             input logic [15:0] fw);
        drain();
        reg_write(REG_TIME_STEP, ts);
        reg_write(REG_INVERSE_TRACK, it);
        reg_write(REG_FILTER_WEIGHT, fw);
    endtask

    task automatic send_tick(input logic [15:0] lw, input logic [15:0] rw,
                             input int gap);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data.left_wheel_speed <= lw;
        i_in_data.right_wheel_speed <= rw;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_tick('{left_wheel_speed: lw, right_wheel_speed: rw});
        ticks_sent++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        return ($urandom_range(0, 15) == 0) ? $urandom_range(30, 200)
                                            : $urandom_range(0, 3);
    endfunction

    function automatic logic [15:0] pick_speed(input int mode);
        case (mode)
            0: return 16'($signed($urandom_range(0, 4096)) - 2048);
            1: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] lw, rw;
        int mode;
        i_rst_n <= 0;
        i_in_valid <= 0;
        i_in_data <= '0;
        psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        running = 1;

        // directed: speed extremes at reset settings
        send_tick(16'h7fff, 16'h7fff, 0);
        send_tick(16'h8000, 16'h8000, 1);
        send_tick(16'h7fff, 16'h8000, 0);
        send_tick(16'h0000, 16'h0000, 0);
        // instant filter, big turn rate and step: heading wraps on the turning ticks
        configure(16'hffff, 16'hffff, 16'hffff);
        send_tick(16'h8000, 16'h7fff, 0);
        send_tick(16'h7fff, 16'h8000, 0);
        send_tick(16'h8000, 16'h7fff, 2);
        send_tick(16'h1000, 16'h1400, 0);
        send_tick(16'h7fff, 16'h7fff, 0);
        send_tick(16'h8000, 16'h8000, 0);
        // frozen filter, zero-ish step and track
        configure(16'd1, 16'd1, 16'd0);
        send_tick(16'h7fff, 16'h8000, 0);
        send_tick(16'h1234, 16'h4321, 0);
        // walk the heading through the quadrant boundaries
        configure(16'd40000, 16'd256, 16'hffff);
        for (int i = 0; i < 10; i++) send_tick(16'hf000, 16'h1000, 0);

        // long receiver hold while ticks keep coming
        hold_request = 800;
        for (int i = 0; i < 8; i++) send_tick(16'h0800, 16'h0c00, 0);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure(RST_TIME_STEP, RST_INVERSE_TRACK, RST_FILTER_WEIGHT);
                1: configure(16'hffff, 16'hffff, 16'hffff);
                2: configure(16'd1, 16'd1, 16'd0);
                default: configure(16'($urandom_range(1, 65535)),
                                   16'($urandom_range(1, 65535)),
                                   16'($urandom_range(0, 65535)));
            endcase
            for (int i = 0; i < 300; i++) begin
                // straight or steady-turn stretches, with random noise ticks mixed in
                if (i % 40 == 0) begin
                    mode = $urandom_range(0, 2);
                    lw = pick_speed(mode);
                    rw = ($urandom_range(0, 1)) ? lw : pick_speed(mode);
                end
                if ($urandom_range(0, 4) == 0)
                    send_tick(16'($urandom), 16'($urandom), pick_gap());
                else
                    send_tick(lw, rw, pick_gap());
                if (phase == 3 && i == 150) begin
                    drain();
                    hold_request = 600;
                end
            end
        end

        drain();
        $display("Sent %0d ticks over ten register settings; %0d poses checked.",
                 ticks_sent, sb.checked);
        if (sb.errors == 0 && sb.poses.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
